@@ sv/fts_pkg.sv @@
`default_nettype none

package fts_pkg;

  localparam int NumTasks = 4;
  localparam int SlotW    = $clog2(NumTasks);
  localparam int TaskW    = 3;
  localparam int BurstW   = 8;
  localparam int CfgIdxW  = 3;
  localparam int PcW      = 3;

  localparam logic [1:0] StReady     = 2'd0;
  localparam logic [1:0] StRunning   = 2'd1;
  localparam logic [1:0] StSuspended = 2'd2;

  localparam logic [BurstW-1:0] BurstReset = BurstW'(3);

  localparam logic [PcW-1:0] PcIdle  = PcW'(0);
  localparam logic [PcW-1:0] PcWake  = PcW'(1);
  localparam logic [PcW-1:0] PcScan  = PcW'(2);
  localparam logic [PcW-1:0] PcServe = PcW'(3);
  localparam logic [PcW-1:0] PcEmit  = PcW'(4);

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_WAKE,
    OP_SCAN,
    OP_SERVE,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    C_NONE,
    C_WAIT_IN,
    C_SCAN_LOOP,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PcW-1:0]   target;
  } uword_t;

  typedef struct packed {
    logic fire;
    logic tick;
    logic scan_last;
    logic out_busy;
  } seq_cond_t;

  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    w = '{op: OP_IDLE, cond: C_WAIT_IN, target: PcEmit};
    unique case (pc)
      PcIdle:  w = '{op: OP_IDLE,  cond: C_WAIT_IN,   target: PcEmit};
      PcWake:  w = '{op: OP_WAKE,  cond: C_NONE,      target: PcIdle};
      PcScan:  w = '{op: OP_SCAN,  cond: C_SCAN_LOOP, target: PcIdle};
      PcServe: w = '{op: OP_SERVE, cond: C_NONE,      target: PcIdle};
      PcEmit:  w = '{op: OP_EMIT,  cond: C_OUT_BUSY,  target: PcIdle};
      default: w = '{op: OP_IDLE,  cond: C_WAIT_IN,   target: PcEmit};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ sv/fts_useq.sv @@
`default_nettype none

module fts_useq (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  fts_pkg::seq_cond_t  cond_i,
  output fts_pkg::op_e        op_o,
  output logic                at_idle_o
);
  import fts_pkg::*;

  logic [PcW-1:0] pc_q, pc_d, pc_inc;
  uword_t         uw;

  assign uw        = ucode(pc_q);
  assign op_o      = uw.op;
  assign at_idle_o = (pc_q == PcIdle);
  assign pc_inc    = pc_q + PcW'(1);

  always_comb begin
    pc_d = pc_inc;
    unique case (uw.cond)
      C_NONE:      pc_d = pc_inc;
      C_WAIT_IN: begin
        priority if (!cond_i.fire) pc_d = pc_q;
        else if (!cond_i.tick)     pc_d = uw.target;
        else                       pc_d = pc_inc;
      end
      C_SCAN_LOOP: pc_d = cond_i.scan_last ? pc_inc : pc_q;
      C_OUT_BUSY:  pc_d = cond_i.out_busy ? pc_q : uw.target;
      default:     pc_d = PcIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/fifo_task_scheduler_top.sv @@
// Each item runs through the microprogram steps: a high tick item through accept, wake, four
// scan steps (one task per step), serve and emit; a low tick item through accept and emit.
// A new item is accepted only at the accept step, once the previous item has left the emit step.
// The result sits in an output register; a stalled result holds the emit step.
// Reset: all tasks ready, ready queue empty, run counter zero, every burst 3.
// The configuration port is always ready.
`default_nettype none

module fifo_task_scheduler_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          tick_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic                         active_o,
  output logic [fts_pkg::TaskW-1:0]    task_served_o,
  output logic [fts_pkg::BurstW-1:0]   elapsed_o,
  output logic                         finished_o,
  output logic [fts_pkg::TaskW-1:0]    queue_count_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [fts_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire  [fts_pkg::BurstW-1:0]   cfg_data_i
);
  import fts_pkg::*;

  logic [BurstW-1:0] burst_q [NumTasks];
  logic [TaskW-1:0]  queue_q [NumTasks];
  logic [1:0]        status_q [NumTasks];
  logic [TaskW-1:0]  fill_q;
  logic [BurstW-1:0] ctr_q;
  logic [SlotW-1:0]  idx_q;

  logic              res_act_q, res_fin_q;
  logic [TaskW-1:0]  res_id_q;
  logic [BurstW-1:0] res_elap_q;

  logic              out_valid_q;
  logic              out_act_q, out_fin_q;
  logic [TaskW-1:0]  out_id_q, out_cnt_q;
  logic [BurstW-1:0] out_elap_q;

  op_e               op;
  logic              at_idle;
  seq_cond_t         cond;
  logic              fire, out_busy;

  logic [TaskW-1:0]  scan_id;
  logic              scan_in_q, scan_add;
  logic [TaskW-1:0]  head_id;
  logic [SlotW-1:0]  head_t;

  assign in_ready_o  = at_idle;
  assign fire        = in_valid_i && at_idle;
  assign out_busy    = out_valid_q && !out_ready_i;
  assign cfg_ready_o = 1'b1;

  assign cond = '{fire: fire, tick: tick_i,
                  scan_last: (idx_q == SlotW'(NumTasks - 1)), out_busy: out_busy};

  fts_useq u_useq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cond_i    (cond),
    .op_o      (op),
    .at_idle_o (at_idle)
  );

  assign scan_id = TaskW'(idx_q) + TaskW'(1);
  always_comb begin
    scan_in_q = 1'b0;
    for (int k = 0; k < NumTasks; k++) begin
      if ((TaskW'(k) < fill_q) && (queue_q[k] == scan_id)) scan_in_q = 1'b1;
    end
  end
  assign scan_add = (status_q[idx_q] == StReady) && !scan_in_q
                    && (fill_q < TaskW'(NumTasks));

  assign head_id = queue_q[0];
  assign head_t  = head_id[SlotW-1:0] - SlotW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumTasks; i++) begin
        burst_q[i]  <= BurstReset;
        queue_q[i]  <= '0;
        status_q[i] <= StReady;
      end
      fill_q      <= '0;
      ctr_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && (cfg_index_i < CfgIdxW'(NumTasks))) begin
        burst_q[cfg_index_i[SlotW-1:0]] <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i && (op != OP_EMIT)) out_valid_q <= 1'b0;

      unique case (op)
        OP_IDLE: ;
        OP_WAKE: begin
          for (int i = 0; i < NumTasks; i++) begin
            if (status_q[i] == StSuspended) status_q[i] <= StReady;
          end
          idx_q <= '0;
        end
        OP_SCAN: begin
          if (scan_add) begin
            queue_q[fill_q[SlotW-1:0]] <= scan_id;
            fill_q <= fill_q + TaskW'(1);
          end
          idx_q <= idx_q + SlotW'(1);
        end
        OP_SERVE: begin
          if (fill_q != '0) begin
            if (ctr_q <= burst_q[head_t]) begin
              status_q[head_t] <= StRunning;
              ctr_q <= ctr_q + BurstW'(1);
            end else begin
              status_q[head_t] <= StSuspended;
              ctr_q <= '0;
              for (int i = 0; i < NumTasks - 1; i++) queue_q[i] <= queue_q[i+1];
              queue_q[NumTasks-1] <= '0;
              fill_q <= fill_q - TaskW'(1);
            end
          end
        end
        OP_EMIT: begin
          if (!out_busy) out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result working registers and output register: payload only
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_act_q  <= 1'b0;
      res_fin_q  <= 1'b0;
      res_id_q   <= '0;
      res_elap_q <= '0;
    end
    if ((op == OP_SERVE) && (fill_q != '0)) begin
      res_act_q  <= 1'b1;
      res_id_q   <= head_id;
      res_elap_q <= ctr_q;
      res_fin_q  <= !(ctr_q <= burst_q[head_t]);
    end
    if ((op == OP_EMIT) && !out_busy) begin
      out_act_q  <= res_act_q;
      out_id_q   <= res_id_q;
      out_elap_q <= res_elap_q;
      out_fin_q  <= res_fin_q;
      out_cnt_q  <= fill_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign active_o      = out_act_q;
  assign task_served_o = out_id_q;
  assign elapsed_o     = out_elap_q;
  assign finished_o    = out_fin_q;
  assign queue_count_o = out_cnt_q;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fts_pkg::*;

  localparam int Limit = 1_000_000;
  localparam int RandomItems = 850;

  typedef struct packed {
    logic              active;
    logic [TaskW-1:0]  task_id;
    logic [BurstW-1:0] elapsed;
    logic              finished;
    logic [TaskW-1:0]  queue_count;
  } sched_res_t;

  typedef enum logic [1:0] {
    RxFree,
    RxCoin,
    RxSlow,
    RxToggle
  } rx_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_tick = 1'b0;
  logic               out_ready = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [BurstW-1:0]  cfg_data = '0;

  wire                in_ready_o;
  wire                out_valid_o;
  wire                active_o;
  wire [TaskW-1:0]    task_served_o;
  wire [BurstW-1:0]   elapsed_o;
  wire                finished_o;
  wire [TaskW-1:0]    queue_count_o;
  wire                cfg_ready_o;

  fifo_task_scheduler_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .tick_i        (in_tick),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .active_o      (active_o),
    .task_served_o (task_served_o),
    .elapsed_o     (elapsed_o),
    .finished_o    (finished_o),
    .queue_count_o (queue_count_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // scheduler state as predicted
  logic [BurstW-1:0] burst_model  [NumTasks];
  logic [TaskW-1:0]  run_queue    [NumTasks];
  logic [TaskW-1:0]  queue_fill;
  logic [1:0]        task_state   [NumTasks];
  logic [BurstW-1:0] run_count;

  logic [BurstW-1:0] next_burst   [NumTasks];

  logic       pending_ticks [$];
  sched_res_t due_results   [$];

  int  fail_count = 0;
  int  results_seen = 0;
  int  cycle_count = 0;
  bit  in_taken = 1'b0;

  function automatic sched_res_t advance_tick(input logic tick);
    sched_res_t       r;
    logic [TaskW-1:0] head;
    logic [SlotW-1:0] slot;
    bit               queued;
    int               t;
    int               k;
    r = '0;
    if (tick) begin
      for (t = 0; t < NumTasks; t++) begin
        if (task_state[t] == StSuspended) task_state[t] = StReady;
      end
      for (t = 0; t < NumTasks && queue_fill < NumTasks; t++) begin
        queued = 1'b0;
        for (k = 0; k < queue_fill; k++) begin
          if (run_queue[k] == TaskW'(t + 1)) queued = 1'b1;
        end
        if (task_state[t] == StReady && !queued) begin
          run_queue[queue_fill[SlotW-1:0]] = TaskW'(t + 1);
          queue_fill++;
        end
      end
      if (queue_fill > 0) begin
        head = run_queue[0];
        slot = SlotW'(head - 1'b1);
        task_state[slot] = StRunning;
        r.active  = 1'b1;
        r.task_id = head;
        r.elapsed = run_count;
        if (run_count <= burst_model[slot]) begin
          run_count = run_count + 1'b1;
        end else begin
          r.finished = 1'b1;
          run_count = '0;
          task_state[slot] = StSuspended;
          for (k = 0; k < NumTasks - 1; k++) run_queue[k] = run_queue[k + 1];
          run_queue[NumTasks - 1] = '0;
          queue_fill--;
        end
      end
    end
    r.queue_count = queue_fill;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [BurstW-1:0] want,
                             input logic [BurstW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // monitor: result checking and prediction
  always @(posedge clk_i) begin : monitor
    sched_res_t want;
    cycle_count++;
    if (cycle_count > Limit) begin
      $display("Verification failed");
      $finish;
    end else begin
      in_taken <= rst_ni && in_valid && in_ready_o;
      if (rst_ni) begin
        if (out_valid_o && out_ready) begin
          results_seen++;
          if (due_results.size() == 0) begin
            $error("result with no item pending: task %0d elapsed %0d",
                   task_served_o, elapsed_o);
            fail_count++;
          end else begin
            want = due_results.pop_front();
            check_field("active", BurstW'(want.active), BurstW'(active_o));
            check_field("task_served", BurstW'(want.task_id), BurstW'(task_served_o));
            check_field("elapsed", want.elapsed, elapsed_o);
            check_field("finished", BurstW'(want.finished), BurstW'(finished_o));
            check_field("queue_count", BurstW'(want.queue_count), BurstW'(queue_count_o));
          end
        end
        if (in_valid && in_ready_o) due_results.push_back(advance_tick(in_tick));
      end
    end
  end

  // sender: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_ticks.size() > 0) begin
        in_valid <= 1'b1;
        in_tick <= pending_ticks.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall patterns, one long hold-off, occasional random hold-offs
  rx_mode_e rx_mode = RxFree;
  int       mode_left = 0;
  int       hold_left = 0;
  bit       long_hold_done = 1'b0;
  bit       rx_phase = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (!long_hold_done && results_seen >= 600) begin
        long_hold_done = 1'b1;
        hold_left = 400;
      end else if (hold_left == 0 && $urandom_range(0, 2999) == 0) begin
        hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 80);
        end else begin
          mode_left--;
        end
        rx_phase = !rx_phase;
        case (rx_mode)
          RxFree:   out_ready <= 1'b1;
          RxCoin:   out_ready <= 1'($urandom_range(0, 1));
          RxSlow:   out_ready <= ($urandom_range(0, 3) == 0);
          default:  out_ready <= rx_phase;
        endcase
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [BurstW-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NumTasks) burst_model[idx[SlotW-1:0]] = val;
  endtask

  task automatic program_bursts(input bit poke_unused);
    int t;
    if (poke_unused) begin
      write_reg(CfgIdxW'(NumTasks + $urandom_range(0, (1 << CfgIdxW) - NumTasks - 1)),
                BurstW'($urandom_range(0, 255)));
    end
    for (t = 0; t < NumTasks; t++) write_reg(CfgIdxW'(t), next_burst[t]);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_ticks(input int count);
    int n;
    for (n = 0; n < count; n++) pending_ticks.push_back($urandom_range(0, 7) != 0);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_ticks.size() != 0 || in_valid || due_results.size() != 0);
    repeat (16) @(posedge clk_i);
  endtask

  function automatic logic [BurstW-1:0] pick_burst();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return BurstW'(254);
      2:       return BurstW'($urandom_range(0, 254));
      default: return BurstW'($urandom_range(0, 6));
    endcase
  endfunction

  initial begin : main
    int t;
    int n;
    int random_done;
    int phase_len;
    for (t = 0; t < NumTasks; t++) begin
      burst_model[t] = BurstReset;
      run_queue[t] = '0;
      task_state[t] = StReady;
    end
    queue_fill = '0;
    run_count = '0;
    random_done = 0;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset bursts: idle ticks on an empty queue, then high ticks with one low tick among them
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b0);
    for (n = 0; n < 20; n++) pending_ticks.push_back(n != 9);
    wait_drained();

    // zero bursts, unused register index
    for (t = 0; t < NumTasks; t++) next_burst[t] = '0;
    program_bursts(1'b1);
    for (n = 0; n < 20; n++) pending_ticks.push_back(1'b1);
    wait_drained();

    // long burst runs to completion
    next_burst[0] = BurstW'(254);
    next_burst[1] = BurstW'(1);
    next_burst[2] = '0;
    next_burst[3] = BurstW'(2);
    program_bursts(1'b0);
    for (n = 0; n < 270; n++) pending_ticks.push_back(1'b1);
    wait_drained();

    // bursts of 255: head never leaves, counter wraps
    for (t = 0; t < NumTasks; t++) next_burst[t] = '1;
    program_bursts(1'b1);
    queue_ticks(300);
    wait_drained();

    while (random_done < RandomItems) begin
      for (t = 0; t < NumTasks; t++) next_burst[t] = pick_burst();
      program_bursts($urandom_range(0, 2) == 0);
      phase_len = $urandom_range(40, 120);
      queue_ticks(phase_len);
      random_done += phase_len;
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
sv/fts_pkg.sv
sv/fts_useq.sv
sv/fifo_task_scheduler_top.sv
tb/tb.sv
